### hdl/imsfp_pkg.sv
// ----------------------------------------------------------------------------
// IMU serial frame parser package
// Shared types, codes and constants of the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package imsfp_pkg;

   localparam int BYTE_WIDTH = 8;
   localparam int POS_WIDTH = 4;
   localparam int WORD_WIDTH = 16;
   localparam int TEMP_WIDTH = 15;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int PAYLOAD_DEPTH = 8;
   localparam int PAYLOAD_ADDR_WIDTH = $clog2(PAYLOAD_DEPTH);
   localparam int TEMP_MAG_WIDTH = 18;
   localparam int TEMP_Q_WIDTH = 14;

   localparam logic [BYTE_WIDTH-1:0] SYNC_BYTE = 8'h55;
   localparam logic [BYTE_WIDTH-1:0] TYPE_ACCEL = 8'h51;
   localparam logic [BYTE_WIDTH-1:0] TYPE_GYRO = 8'h52;
   localparam logic [BYTE_WIDTH-1:0] TYPE_ANGLE = 8'h53;

   localparam logic [POS_WIDTH-1:0] FRAME_LEN = 4'd11;
   localparam logic [POS_WIDTH-1:0] CHECKSUM_POS = 4'd10;
   localparam logic [POS_WIDTH-1:0] TYPE_POS = 4'd1;
   localparam logic [POS_WIDTH-1:0] PAYLOAD_POS = 4'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ERROR_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DROP_BAD = 8'd1;

   localparam logic [BYTE_WIDTH-1:0] ERROR_LIMIT_RESET = 8'd100;
   localparam logic [BYTE_WIDTH-1:0] TALLY_MAX = 8'hFF;

   // Division by 17 as multiplication by ceil(2^22 / 17), exact for the
   // magnitude range of the scaled temperature word.
   localparam int TEMP_SHIFT = 22;
   localparam logic [TEMP_MAG_WIDTH-1:0] TEMP_RECIP = 18'd246724;
   localparam logic signed [WORD_WIDTH-1:0] TEMP_OFFSET = 16'sd3625;

   typedef enum logic [1:0] {
      MODE_HUNT,
      MODE_CONFIRM,
      MODE_SKIP,
      MODE_ALIGNED
   } mode_type;

   typedef enum logic [1:0] {
      KIND_ACCEL,
      KIND_GYRO,
      KIND_ANGLE,
      KIND_UNKNOWN
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic [WORD_WIDTH-1:0]      axis_x;
      logic [WORD_WIDTH-1:0]      axis_y;
      logic [WORD_WIDTH-1:0]      axis_z;
      logic [TEMP_MAG_WIDTH-1:0]  temp_mag;
      logic                       temp_neg;
      logic                       checksum_ok;
      logic                       resync_started;
   } frame_type;

endpackage

`default_nettype wire

### hdl/imsfp_if.sv
// ----------------------------------------------------------------------------
// IMU serial frame parser channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface imsfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface imsfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [15:0] axis_x;
   logic signed [15:0] axis_y;
   logic signed [15:0] axis_z;
   logic signed [14:0] temp_centi;
   logic               checksum_ok;
   logic               resync_started;

   modport source (output valid, output kind, output axis_x, output axis_y,
                   output axis_z, output temp_centi, output checksum_ok,
                   output resync_started, input ready);
   modport sink (input valid, input kind, input axis_x, input axis_y,
                 input axis_z, input temp_centi, input checksum_ok,
                 input resync_started, output ready);
endinterface

interface imsfp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/imu_serial_frame_parser_top.sv
// ----------------------------------------------------------------------------
// IMU serial frame parser top level
// Parses 11-byte sensor frames from a byte stream into measurement results.
// ----------------------------------------------------------------------------
// Throughput: one received byte is accepted in every cycle while results drain.
// A result is registered in the first stage, which captures the frame, and then in the
// second stage, which performs the divide-by-17 multiplication, before it is presented.
// Reset clears the parser to the header hunt and restores register defaults.
`default_nettype none

module imu_serial_frame_parser_top (
   input  wire logic    clock,
   input  wire logic    reset,
   imsfp_req_if.sink    req_ch,
   imsfp_rsp_if.source  rsp_ch,
   imsfp_csr_if.sink    csr_ch
);
   import imsfp_pkg::*;

   logic [BYTE_WIDTH-1:0]          error_limit_ff, error_limit_in;
   logic                           drop_bad_ff, drop_bad_in;
   logic                           s1_valid_ff, s1_valid_in;
   frame_type                      s1_frame_ff;
   logic                           out_valid_ff, out_valid_in;
   kind_type                       out_kind_ff;
   logic [WORD_WIDTH-1:0]          out_x_ff, out_y_ff, out_z_ff;
   logic [TEMP_WIDTH-1:0]          out_temp_ff, out_temp_in;
   logic                           out_ok_ff, out_resync_ff;
   logic                           stage_b_ready;
   logic                           s1_ready;
   logic                           accept;
   logic                           frame_valid;
   frame_type                      frame;
   logic [2*TEMP_MAG_WIDTH-1:0]    temp_prod;
   logic [TEMP_Q_WIDTH-1:0]        temp_q;
   logic signed [WORD_WIDTH-1:0]   temp_signed;
   logic signed [WORD_WIDTH-1:0]   temp_sum;

   assign stage_b_ready = !out_valid_ff || rsp_ch.ready;
   assign s1_ready = !s1_valid_ff || stage_b_ready;
   assign req_ch.ready = s1_ready;
   assign accept = req_ch.valid && s1_ready;
   assign csr_ch.ready = 1'b1;

   imsfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_ch.rx_byte),
      .error_limit (error_limit_ff),
      .drop_bad    (drop_bad_ff),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   always_comb begin
      error_limit_in = error_limit_ff;
      drop_bad_in = drop_bad_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ERROR_LIMIT: error_limit_in = csr_ch.data;
            CSR_DROP_BAD: drop_bad_in = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   assign s1_valid_in = s1_ready ? frame_valid : s1_valid_ff;
   assign out_valid_in = stage_b_ready ? s1_valid_ff : out_valid_ff;

   assign temp_prod = s1_frame_ff.temp_mag * TEMP_RECIP;
   assign temp_q = temp_prod[TEMP_SHIFT +: TEMP_Q_WIDTH];
   assign temp_signed = s1_frame_ff.temp_neg ? -$signed({2'b00, temp_q})
                                             : $signed({2'b00, temp_q});
   assign temp_sum = temp_signed + TEMP_OFFSET;
   assign out_temp_in = (s1_frame_ff.kind == KIND_UNKNOWN) ? '0
                                                           : temp_sum[TEMP_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         error_limit_ff <= ERROR_LIMIT_RESET;
         drop_bad_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         error_limit_ff <= error_limit_in;
         drop_bad_ff <= drop_bad_in;
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && frame_valid) begin
         s1_frame_ff <= frame;
      end
      if (stage_b_ready && s1_valid_ff) begin
         out_kind_ff <= s1_frame_ff.kind;
         out_x_ff <= s1_frame_ff.axis_x;
         out_y_ff <= s1_frame_ff.axis_y;
         out_z_ff <= s1_frame_ff.axis_z;
         out_temp_ff <= out_temp_in;
         out_ok_ff <= s1_frame_ff.checksum_ok;
         out_resync_ff <= s1_frame_ff.resync_started;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.kind = out_kind_ff;
   assign rsp_ch.axis_x = out_x_ff;
   assign rsp_ch.axis_y = out_y_ff;
   assign rsp_ch.axis_z = out_z_ff;
   assign rsp_ch.temp_centi = out_temp_ff;
   assign rsp_ch.checksum_ok = out_ok_ff;
   assign rsp_ch.resync_started = out_resync_ff;

   a_frame_needs_accept: assert property (@(posedge clock) disable iff (reset)
      frame_valid |-> accept)
      else $error("frame completed without an accepted byte");

   a_stage_one_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !stage_b_ready) |=> (s1_valid_ff && $stable(s1_frame_ff)))
      else $error("stalled frame lost from the first stage");

   a_unknown_kind_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_UNKNOWN) |->
         (out_temp_ff == '0 && out_x_ff == '0 && out_y_ff == '0 && out_z_ff == '0))
      else $error("unknown frame type carries non-zero measurements");

   a_resync_on_error: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_resync_ff) |-> !out_ok_ff)
      else $error("resynchronisation reported for a good frame");

   a_drop_bad: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && drop_bad_ff) |-> out_ok_ff)
      else $error("bad frame delivered while bad frames are dropped");

endmodule

`default_nettype wire

### hdl/imsfp_parser.sv
// ----------------------------------------------------------------------------
// IMU serial frame parser core
// Byte-wise alignment hunt, frame capture, checksum and error counting.
// ----------------------------------------------------------------------------
`default_nettype none

module imsfp_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [imsfp_pkg::BYTE_WIDTH-1:0] rx_byte,
   input  wire logic [imsfp_pkg::BYTE_WIDTH-1:0] error_limit,
   input  wire logic                          drop_bad,
   output      logic                          frame_valid,
   output      imsfp_pkg::frame_type          frame
);
   import imsfp_pkg::*;

   mode_type                mode_ff, mode_in;
   logic [POS_WIDTH-1:0]    pos_ff, pos_in;
   logic [BYTE_WIDTH-1:0]   sum_ff, sum_in;
   logic [BYTE_WIDTH-1:0]   tally_ff, tally_in;
   logic [BYTE_WIDTH-1:0]   type_ff;
   logic [BYTE_WIDTH-1:0]   payload_ff [PAYLOAD_DEPTH];
   logic                    type_we;
   logic                    payload_we;
   logic [POS_WIDTH-1:0]    pos_inc;
   logic [POS_WIDTH-1:0]    payload_off;
   logic [WORD_WIDTH-1:0]   word_t;
   logic signed [TEMP_MAG_WIDTH:0] temp_x5;
   logic                    ok;
   kind_type                kind;

   assign pos_inc = pos_ff + 1'b1;
   assign payload_off = pos_ff - PAYLOAD_POS;
   assign word_t = {payload_ff[7], payload_ff[6]};
   assign temp_x5 = $signed({{3{word_t[15]}}, word_t})
                    + $signed({word_t[15], word_t, 2'b00});
   assign ok = (sum_ff == rx_byte);

   always_comb begin
      case (type_ff)
         TYPE_ACCEL: kind = KIND_ACCEL;
         TYPE_GYRO: kind = KIND_GYRO;
         TYPE_ANGLE: kind = KIND_ANGLE;
         default: kind = KIND_UNKNOWN;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      tally_in = tally_ff;
      type_we = 1'b0;
      payload_we = 1'b0;
      frame_valid = 1'b0;
      frame.kind = kind;
      frame.axis_x = (kind == KIND_UNKNOWN) ? '0 : {payload_ff[1], payload_ff[0]};
      frame.axis_y = (kind == KIND_UNKNOWN) ? '0 : {payload_ff[3], payload_ff[2]};
      frame.axis_z = (kind == KIND_UNKNOWN) ? '0 : {payload_ff[5], payload_ff[4]};
      frame.temp_neg = temp_x5[TEMP_MAG_WIDTH];
      frame.temp_mag = temp_x5[TEMP_MAG_WIDTH] ? TEMP_MAG_WIDTH'(-temp_x5)
                                               : temp_x5[TEMP_MAG_WIDTH-1:0];
      frame.checksum_ok = ok;
      frame.resync_started = 1'b0;
      if (accept) begin
         case (mode_ff)
            MODE_CONFIRM: begin
               pos_in = pos_inc;
               if (pos_inc >= FRAME_LEN) begin
                  pos_in = '0;
                  mode_in = (rx_byte == SYNC_BYTE) ? MODE_SKIP : MODE_HUNT;
               end
            end
            MODE_SKIP: begin
               pos_in = pos_inc;
               if (pos_inc >= CHECKSUM_POS) begin
                  pos_in = '0;
                  sum_in = '0;
                  tally_in = '0;
                  mode_in = MODE_ALIGNED;
               end
            end
            MODE_ALIGNED: begin
               if (pos_ff < CHECKSUM_POS) begin
                  sum_in = sum_ff + rx_byte;
                  type_we = (pos_ff == TYPE_POS);
                  payload_we = (pos_ff >= PAYLOAD_POS);
                  pos_in = pos_inc;
               end else begin
                  pos_in = '0;
                  sum_in = '0;
                  if (!ok) begin
                     if (tally_ff != TALLY_MAX) begin
                        tally_in = tally_ff + 1'b1;
                     end
                     if (tally_in >= error_limit) begin
                        frame.resync_started = 1'b1;
                        mode_in = MODE_HUNT;
                     end
                  end
                  frame_valid = ok || !drop_bad;
               end
            end
            default: begin
               pos_in = '0;
               mode_in = (rx_byte == SYNC_BYTE) ? MODE_CONFIRM : MODE_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HUNT;
         pos_ff <= '0;
         sum_ff <= '0;
         tally_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         tally_ff <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (type_we) begin
         type_ff <= rx_byte;
      end
      if (payload_we) begin
         payload_ff[payload_off[PAYLOAD_ADDR_WIDTH-1:0]] <= rx_byte;
      end
   end

endmodule

`default_nettype wire
